// File: rtl/core/glqr_pkg.sv
// Shared types, step codes, register map and gain coefficients for the LQR wheel controller.
package glqr_pkg;

    localparam int MUL_W  = 33;
    localparam int PROD_W = 64;

    // Register indexes on the configuration port.
    localparam logic [1:0] REG_TORQUE_GAIN = 2'd0;
    localparam logic [1:0] REG_RPM_SCALE   = 2'd1;
    localparam logic [1:0] REG_LOOP_PERIOD = 2'd2;

    // Sequencer step codes.
    localparam logic [2:0] OP_SPEED  = 3'd0;
    localparam logic [2:0] OP_POS    = 3'd1;
    localparam logic [2:0] OP_HORNER = 3'd2;
    localparam logic [2:0] OP_DOT    = 3'd3;
    localparam logic [2:0] OP_UHI    = 3'd4;
    localparam logic [2:0] OP_ULO    = 3'd5;

    localparam logic [2:0] LAST_GAIN   = 3'd5;
    localparam logic [1:0] LAST_HORNER = 2'd3;

    localparam logic signed [31:0] HALF_PI_Q16 = 32'sd102944;
    localparam logic [63:0]        TRUNC_BIAS  = 64'h0000_0000_01FF_FFFF;

    typedef struct packed {
        logic [2:0] op;
        logic [2:0] gain_idx;
        logic [1:0] horner_idx;
        logic       wb;
        logic       fin;
        logic       idle;
    } glqr_ctrl_t;

    // Cubic gain coefficients in Q16.16, highest power first.
    localparam logic signed [31:0] GLQR_COEF [0:5][0:3] = '{
        '{-32'sd14376750,  32'sd15928191, -32'sd8654173, -32'sd453883},
        '{ 32'sd95014,    -32'sd247516,   -32'sd701989,  -32'sd8546},
        '{ 32'sd934819,   -32'sd901743,    32'sd264477,  -32'sd323381},
        '{ 32'sd1721860,  -32'sd1621446,   32'sd346377,  -32'sd443974},
        '{-32'sd19381892,  32'sd19496652, -32'sd6753649,  32'sd508566},
        '{-32'sd4396037,   32'sd4454004,  -32'sd1561179,  32'sd149481}
    };

    function automatic logic signed [31:0] glqr_coef(input logic [2:0] gi, input logic [1:0] hj);
        logic signed [31:0] c;
        if (gi <= LAST_GAIN)
            c = GLQR_COEF[gi][hj];
        else
            c = '0;
        return c;
    endfunction

endpackage

// File: rtl/core/glqr_mul.sv
// Shared signed multiplier with a registered product.
module glqr_mul
    import glqr_pkg::*;
(
    input  logic                     clk,
    input  logic signed [MUL_W-1:0]  a,
    input  logic signed [MUL_W-1:0]  b,
    output logic signed [PROD_W-1:0] prod_reg
);

    logic signed [2*MUL_W-1:0] full;

    assign full = a * b;

    always_ff @(posedge clk)
    begin
        prod_reg <= full[PROD_W-1:0];
    end

endmodule

// File: rtl/core/glqr_seq.sv
// Step sequencer that drives the shared multiplier through one control tick.
module glqr_seq
    import glqr_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    input  logic       enable,
    input  logic       slot_free,
    output glqr_ctrl_t ctrl
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_FIN  = 2'd2;

    logic [1:0] state_reg, state_next;
    logic       phase_reg, phase_next;
    logic [2:0] op_reg, op_next;
    logic [2:0] gi_reg, gi_next;
    logic [1:0] hj_reg, hj_next;

    always_comb
    begin
        state_next = state_reg;
        phase_next = phase_reg;
        op_next    = op_reg;
        gi_next    = gi_reg;
        hj_next    = hj_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_RUN;
                    phase_next = 1'b0;
                    op_next    = OP_SPEED;
                    gi_next    = 3'd0;
                    hj_next    = 2'd1;
                end
            end
            ST_RUN:
            begin
                if (!phase_reg)
                begin
                    phase_next = 1'b1;
                end
                else
                begin
                    phase_next = 1'b0;
                    unique case (op_reg)
                        OP_SPEED: op_next = OP_POS;
                        OP_POS:
                        begin
                            if (enable)
                                op_next = OP_HORNER;
                            else
                                state_next = ST_FIN;
                        end
                        OP_HORNER:
                        begin
                            if (hj_reg == LAST_HORNER)
                                op_next = OP_DOT;
                            else
                                hj_next = hj_reg + 2'd1;
                        end
                        OP_DOT:
                        begin
                            if (gi_reg == LAST_GAIN)
                            begin
                                op_next = OP_UHI;
                            end
                            else
                            begin
                                op_next = OP_HORNER;
                                gi_next = gi_reg + 3'd1;
                                hj_next = 2'd1;
                            end
                        end
                        OP_UHI:  op_next = OP_ULO;
                        default: state_next = ST_FIN;
                    endcase
                end
            end
            ST_FIN:
            begin
                if (slot_free)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            phase_reg <= 1'b0;
            op_reg    <= OP_SPEED;
            gi_reg    <= 3'd0;
            hj_reg    <= 2'd1;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            op_reg    <= op_next;
            gi_reg    <= gi_next;
            hj_reg    <= hj_next;
        end
    end

    assign ctrl.op         = op_reg;
    assign ctrl.gain_idx   = gi_reg;
    assign ctrl.horner_idx = hj_reg;
    assign ctrl.wb         = (state_reg == ST_RUN) && phase_reg;
    assign ctrl.fin        = (state_reg == ST_FIN) && slot_free;
    assign ctrl.idle       = (state_reg == ST_IDLE);

endmodule

// File: rtl/core/gain_scheduled_lqr_wheel.sv
// Top level of the gain-scheduled LQR wheel controller: ports, datapath and state.
// An enabled item runs 28 multiplier steps from acceptance to its result item, a
// disabled one only the speed and position steps; each step issues, then writes back.
// One item at a time; the next item is accepted once the result is in the
// output register.
// Reset clears the position estimate, held currents and output valid, and loads the
// register defaults; no clearing pass is needed.
module gain_scheduled_lqr_wheel
    import glqr_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // pitch_angle, pitch_rate, left_leg_length, right_leg_length, left_leg_angle,
    // right_leg_angle, right_wheel_rpm, left_wheel_rpm (16 bits each), lqr_enable, zero pad
    input  logic [135:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // right_current [15:0], left_current [31:16], saturated [32], zero pad
    output logic [39:0]  m_tdata,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [3:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    // Configuration registers.
    logic [15:0] tg_reg;
    logic [23:0] scale_reg;
    logic [23:0] period_reg;

    // Captured item, reduced to what the steps need.
    logic signed [15:0] angle_reg;
    logic signed [15:0] rate_reg;
    logic        [15:0] len_reg;
    logic signed [16:0] legsum_reg;
    logic signed [16:0] rpm_diff_reg;
    logic               enable_reg;

    // Working registers.
    logic signed [31:0]       speed_reg;
    logic signed [31:0]       pos_reg;
    logic signed [31:0]       k_reg;
    logic signed [PROD_W-1:0] acc_reg;
    logic        [15:0]       u_lo_reg;
    logic signed [15:0]       held_right_reg;
    logic signed [15:0]       held_left_reg;

    // Output register.
    logic        m_tvalid_reg;
    logic [15:0] out_right_reg;
    logic [15:0] out_left_reg;
    logic        out_sat_reg;

    glqr_ctrl_t ctrl;
    logic       accept;
    logic       slot_free;
    logic       cfg_write;

    logic signed [MUL_W-1:0]  mul_a;
    logic signed [MUL_W-1:0]  mul_b;
    logic signed [PROD_W-1:0] prod;
    logic signed [31:0]       e_val;
    logic signed [31:0]       e_angle;
    logic signed [31:0]       e_rate;
    logic signed [31:0]       coef_now;
    logic signed [31:0]       coef_lead;
    logic signed [PROD_W-1:0] neg_acc;
    logic signed [32:0]       pos_sum;
    logic signed [31:0]       pos_inc;
    logic signed [PROD_W-1:0] rnd;
    logic signed [38:0]       cur;
    logic signed [15:0]       right_val;
    logic signed [15:0]       left_val;
    logic                     right_clip;
    logic                     right_min;

    assign s_tready  = ctrl.idle;
    assign accept    = s_tvalid && s_tready;
    assign slot_free = !m_tvalid_reg || m_tready;
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    // Configuration port: register i sits at byte address 4*i.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tg_reg     <= 16'd256;
            scale_reg  <= 24'd5531;
            period_reg <= 24'd16777;
        end
        else if (cfg_write)
        begin
            unique case (paddr[3:2])
                REG_TORQUE_GAIN: tg_reg     <= pwdata[15:0];
                REG_RPM_SCALE:   scale_reg  <= pwdata[23:0];
                REG_LOOP_PERIOD: period_reg <= pwdata[23:0];
                default:         ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            REG_TORQUE_GAIN: prdata = {16'd0, tg_reg};
            REG_RPM_SCALE:   prdata = {8'd0, scale_reg};
            REG_LOOP_PERIOD: prdata = {8'd0, period_reg};
            default:         prdata = '0;
        endcase
    end

    glqr_seq u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (accept),
        .enable    (enable_reg),
        .slot_free (slot_free),
        .ctrl      (ctrl)
    );

    glqr_mul u_mul (
        .clk      (clk),
        .a        (mul_a),
        .b        (mul_b),
        .prod_reg (prod)
    );

    // State vector element for the current gain. Angles move to Q16.16 by a shift of 4,
    // the pitch rate by 6, and the leg angle mean is the sum shifted by 3.
    assign e_angle = {{12{angle_reg[15]}}, angle_reg, 4'b0};
    assign e_rate  = {{10{rate_reg[15]}}, rate_reg, 6'b0};

    always_comb
    begin
        unique case (ctrl.gain_idx)
            3'd0:    e_val = e_angle + {{12{legsum_reg[16]}}, legsum_reg, 3'b0} - HALF_PI_Q16;
            3'd1:    e_val = e_rate;
            3'd2:    e_val = pos_reg;
            3'd3:    e_val = speed_reg;
            3'd4:    e_val = -e_angle;
            3'd5:    e_val = -e_rate;
            default: e_val = '0;
        endcase
    end

    assign coef_now  = glqr_coef(ctrl.gain_idx, ctrl.horner_idx);
    assign coef_lead = glqr_coef(ctrl.gain_idx, 2'd0);
    assign neg_acc   = -acc_reg;

    // Operand selection for the shared multiplier.
    always_comb
    begin
        unique case (ctrl.op)
            OP_SPEED:
            begin
                mul_a = {{16{rpm_diff_reg[16]}}, rpm_diff_reg};
                mul_b = {9'd0, scale_reg};
            end
            OP_POS:
            begin
                mul_a = {speed_reg[31], speed_reg};
                mul_b = {9'd0, period_reg};
            end
            OP_HORNER:
            begin
                // The first Horner step starts from the leading coefficient.
                if (ctrl.horner_idx == 2'd1)
                begin
                    mul_a = {coef_lead[31], coef_lead};
                end
                else
                begin
                    mul_a = {k_reg[31], k_reg};
                end
                mul_b = {17'd0, len_reg};
            end
            OP_DOT:
            begin
                mul_a = {k_reg[31], k_reg};
                mul_b = {e_val[31], e_val};
            end
            OP_UHI:
            begin
                // Upper part of u = floor(-sum / 2^16), that is bits 63:32 of -sum.
                mul_a = {neg_acc[63], neg_acc[63:32]};
                mul_b = {17'd0, tg_reg};
            end
            OP_ULO:
            begin
                mul_a = {17'd0, u_lo_reg};
                mul_b = {17'd0, tg_reg};
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // Position update with saturation to 32 bits.
    assign pos_inc = prod[55:24];
    assign pos_sum = {pos_reg[31], pos_reg} + {pos_inc[31], pos_inc};

    // Current: u * torque_gain / 2^25 cut toward zero, then clipped to 16 bits.
    assign rnd = acc_reg + (acc_reg[63] ? TRUNC_BIAS : 64'd0);
    assign cur = rnd[63:25];

    always_comb
    begin
        right_clip = 1'b0;
        if (cur > 39'sd32767)
        begin
            right_val  = 16'sh7FFF;
            right_clip = 1'b1;
        end
        else if (cur < -39'sd32768)
        begin
            right_val  = 16'sh8000;
            right_clip = 1'b1;
        end
        else
        begin
            right_val = cur[15:0];
        end
        // Negating the most negative current clips the left wheel.
        right_min = (right_val == 16'sh8000);
        left_val  = right_min ? 16'sh7FFF : -right_val;
    end

    // Input capture and step write back.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            angle_reg    <= s_tdata[15:0];
            rate_reg     <= s_tdata[31:16];
            len_reg      <= 16'(({1'b0, s_tdata[47:32]} + {1'b0, s_tdata[63:48]}) >> 1);
            legsum_reg   <= {s_tdata[79], s_tdata[79:64]} + {s_tdata[95], s_tdata[95:80]};
            rpm_diff_reg <= {s_tdata[111], s_tdata[111:96]} - {s_tdata[127], s_tdata[127:112]};
            enable_reg   <= s_tdata[128];
            acc_reg      <= '0;
        end
        else if (ctrl.wb)
        begin
            unique case (ctrl.op)
                OP_SPEED:  speed_reg <= prod[40:9];
                OP_POS:    ;
                OP_HORNER: k_reg <= prod[47:16] + coef_now;
                OP_DOT:    acc_reg <= acc_reg + prod;
                OP_UHI:
                begin
                    u_lo_reg <= neg_acc[31:16];
                    acc_reg  <= prod;
                end
                OP_ULO:    acc_reg <= {acc_reg[47:0], 16'd0} + prod;
                default:   ;
            endcase
        end
    end

    // Position and held currents are state that persists across items.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg        <= '0;
            held_right_reg <= '0;
            held_left_reg  <= '0;
        end
        else
        begin
            if (ctrl.wb && (ctrl.op == OP_POS))
            begin
                if (pos_sum[32] != pos_sum[31])
                    pos_reg <= pos_sum[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
                else
                    pos_reg <= pos_sum[31:0];
            end
            if (ctrl.fin && enable_reg)
            begin
                held_right_reg <= right_val;
                held_left_reg  <= left_val;
            end
        end
    end

    // Output register: the result waits here while the next item may be accepted.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (ctrl.fin)
        begin
            m_tvalid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.fin)
        begin
            if (enable_reg)
            begin
                out_right_reg <= right_val;
                out_left_reg  <= left_val;
                out_sat_reg   <= right_clip || right_min;
            end
            else
            begin
                out_right_reg <= held_right_reg;
                out_left_reg  <= held_left_reg;
                out_sat_reg   <= 1'b0;
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {7'd0, out_sat_reg, out_left_reg, out_right_reg};

    // The sequencer never writes back while the input side is open.
    a_wb_not_ready: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.wb |-> !s_tready)
        else $error("write back step while ready for input");

    // An accepted item closes the input side on the next cycle.
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input still ready after an accepted item");

    // A result is only loaded when the output register is free.
    a_fin_slot: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.fin |-> (!m_tvalid || m_tready))
        else $error("result loaded over a pending result item");

    // A clipped result sits at a 16-bit limit.
    a_sat_limit: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[32]) |-> (m_tdata[15:0] == 16'h7FFF || m_tdata[15:0] == 16'h8000))
        else $error("saturated flag without a limit value");

    // The two wheel currents mirror each other, but a right 8000 hex pairs with a left 7FFF hex.
    a_mirror: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> ((m_tdata[31:16] + m_tdata[15:0]) == 16'h0000 ||
                      (m_tdata[15:0] == 16'h8000 && m_tdata[31:16] == 16'h7FFF)))
        else $error("left current is not the mirror of the right current");

endmodule

// File: dv/gain_scheduled_lqr_wheel_test.sv
// Self-checking testbench for the gain-scheduled LQR wheel controller.
module gain_scheduled_lqr_wheel_test
    import glqr_pkg::*;
;

    timeunit 1ns;
    timeprecision 1ps;

    // Drain time at the end of the run and settle time before each register
    // write.
    localparam int DRAIN_CYCLES  = 64;
    localparam int SETTLE_CYCLES = 4;
    localparam int CYCLE_LIMIT   = 600000;

    // The register map only has three entries; index three is a hole in it.
    localparam logic [1:0] REG_UNUSED = 2'd3;

    localparam longint POS_MAX = 64'sd2147483647;
    localparam longint POS_MIN = -64'sd2147483648;
    localparam longint HALF_PI = 64'sd102944;

    // One control tick, laid out exactly as on s_tdata (last field lowest).
    typedef struct packed {
        logic [6:0]         pad;
        logic               lqr_enable;
        logic signed [15:0] left_wheel_rpm;
        logic signed [15:0] right_wheel_rpm;
        logic signed [15:0] right_leg_angle;
        logic signed [15:0] left_leg_angle;
        logic [15:0]        right_leg_length;
        logic [15:0]        left_leg_length;
        logic signed [15:0] pitch_rate;
        logic signed [15:0] pitch_angle;
    } tick_t;

    // One wheel command, laid out as on m_tdata.
    typedef struct packed {
        logic [6:0]         pad;
        logic               saturated;
        logic signed [15:0] left_current;
        logic signed [15:0] right_current;
    } wheel_cmd_t;

    typedef enum logic {STEP_TICK, STEP_WRITE} step_kind_t;

    // A row of the directed list: either a tick to send or a register to write.
    // Rows with fixed_on carry a result that is known without the predictor.
    typedef struct {
        step_kind_t  kind;
        tick_t       tick;
        logic [1:0]  reg_idx;
        logic [31:0] reg_value;
        bit          fixed_on;
        wheel_cmd_t  fixed_cmd;
    } step_t;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    // pitch_angle, pitch_rate, left_leg_length, right_leg_length, left_leg_angle,
    // right_leg_angle, right_wheel_rpm, left_wheel_rpm (16 bits each), lqr_enable, zero pad
    logic [135:0] s_tdata = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b1;
    // right_current [15:0], left_current [31:16], saturated [32], zero pad
    logic [39:0]  m_tdata;
    logic         psel = 1'b0;
    logic         penable = 1'b0;
    logic         pwrite = 1'b0;
    logic [3:0]   paddr = '0;
    logic [31:0]  pwdata = '0;
    logic [31:0]  prdata;
    logic         pready;

    // Shadow copy of the registers and of the controller state, at reset values.
    logic [15:0]        torque_gain_q8  = 16'd256;
    logic [23:0]        rpm_scale_q24   = 24'd5531;
    logic [23:0]        loop_period_q24 = 24'd16777;
    int                 position_q16    = 0;
    logic signed [15:0] held_right      = '0;
    logic signed [15:0] held_left       = '0;

    // Cubic gain coefficients, Q16.16, highest power first, one row per state element.
    longint gain_poly [6][4] = '{
        '{-64'sd14376750,  64'sd15928191, -64'sd8654173, -64'sd453883},
        '{ 64'sd95014,    -64'sd247516,   -64'sd701989,  -64'sd8546},
        '{ 64'sd934819,   -64'sd901743,    64'sd264477,  -64'sd323381},
        '{ 64'sd1721860,  -64'sd1621446,   64'sd346377,  -64'sd443974},
        '{-64'sd19381892,  64'sd19496652, -64'sd6753649,  64'sd508566},
        '{-64'sd4396037,   64'sd4454004,  -64'sd1561179,  64'sd149481}
    };

    wheel_cmd_t  pending_cmds [$];
    step_t       directed_steps [$];
    int          fail_count  = 0;
    int unsigned cycle_count = 0;
    int unsigned ready_hold  = 0;
    bit          idling_on   = 1'b1;

    gain_scheduled_lqr_wheel u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #2 clk = ~clk;

    // Hard stop in case the block stops answering.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Clips to the signed 16-bit range and records whether it had to.
    function automatic longint clip16(input longint x, inout bit hit);
        if (x > 32767)
        begin
            hit = 1'b1;
            return 32767;
        end
        if (x < -32768)
        begin
            hit = 1'b1;
            return -32768;
        end
        return x;
    endfunction

    // Works out the wheel command for one tick and advances the shadow state.
    // Gains, state elements and u are Q16.16 in 64 bits; >>> on a signed value floors.
    function automatic wheel_cmd_t predict_wheel_cmd(input tick_t t);
        longint speed, pos, len, sum, k, u, cur, right, left, angle, rate;
        longint e [6];
        bit hit;
        wheel_cmd_t cmd;
        cmd = '0;
        hit = 1'b0;
        angle = longint'(t.pitch_angle) * 16;
        rate  = longint'(t.pitch_rate) * 64;

        // The position integrates on every tick, enabled or not, and saturates.
        speed = ((longint'(t.right_wheel_rpm) - longint'(t.left_wheel_rpm))
                 * longint'(rpm_scale_q24)) >>> 9;
        pos = longint'(position_q16) + ((speed * longint'(loop_period_q24)) >>> 24);
        if (pos > POS_MAX)
            pos = POS_MAX;
        if (pos < POS_MIN)
            pos = POS_MIN;
        position_q16 = int'(pos);

        if (t.lqr_enable)
        begin
            len  = (longint'(t.left_leg_length) + longint'(t.right_leg_length)) / 2;
            e[0] = angle + (longint'(t.left_leg_angle) + longint'(t.right_leg_angle)) * 8
                   - HALF_PI;
            e[1] = rate;
            e[2] = pos;
            e[3] = speed;
            e[4] = -angle;
            e[5] = -rate;
            sum  = 0;
            for (int i = 0; i < 6; i++)
            begin
                k = gain_poly[i][0];
                for (int j = 1; j < 4; j++)
                    k = ((k * len) >>> 16) + gain_poly[i][j];
                sum += k * e[i];
            end
            u   = (-sum) >>> 16;
            cur = u * longint'(torque_gain_q8);
            // The current scaling rounds toward zero, unlike every other step.
            if (cur >= 0)
                cur = cur >>> 25;
            else
                cur = -((-cur) >>> 25);
            right = clip16(cur, hit);
            left  = clip16(-right, hit);
            held_right = 16'(right);
            held_left  = 16'(left);
            cmd.saturated = hit;
        end
        cmd.right_current = held_right;
        cmd.left_current  = held_left;
        return cmd;
    endfunction

    function automatic void check_field(input string name, input longint want,
                                        input longint got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endfunction

    function automatic logic [31:0] setting_value(input logic [1:0] idx);
        case (idx)
            REG_TORQUE_GAIN: return {16'd0, torque_gain_q8};
            REG_RPM_SCALE:   return {8'd0, rpm_scale_q24};
            REG_LOOP_PERIOD: return {8'd0, loop_period_q24};
            default:         return '0;
        endcase
    endfunction

    // Result checker: every accepted item is held against the oldest expectation.
    always @(posedge clk)
    begin
        wheel_cmd_t got;
        wheel_cmd_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = m_tdata;
            if (pending_cmds.size() == 0)
            begin
                $error("result item with nothing expected: right_current %0d",
                       got.right_current);
                fail_count++;
            end
            else
            begin
                want = pending_cmds.pop_front();
                check_field("right_current", want.right_current, got.right_current);
                check_field("left_current", want.left_current, got.left_current);
                check_field("saturated", want.saturated, got.saturated);
            end
        end
    end

    // Receiver back-pressure: m_tready is dropped at random while idling is on.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (ready_hold > 0)
            begin
                ready_hold = ready_hold - 1;
                m_tready <= (ready_hold == 0);
            end
            else if (idling_on && $urandom_range(0, 7) == 0)
            begin
                ready_hold = $urandom_range(1, 4);
                m_tready <= 1'b0;
            end
        end
    end

    // One APB transfer: setup phase, then access phase until pready.
    task automatic apb_access(input logic wr, input logic [1:0] idx,
                              input logic [31:0] wdata, output logic [31:0] rdata);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {idx, 2'b00};
        pwdata  <= wdata;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        rdata = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Registers only change with the block idle: the input side is held off and
    // every outstanding command must have come back first. A known register is
    // read back right after the write.
    task automatic write_setting(input logic [1:0] idx, input logic [31:0] value);
        logic [31:0] rdata;
        s_tvalid <= 1'b0;
        while (pending_cmds.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        apb_access(1'b1, idx, value, rdata);
        case (idx)
            REG_TORQUE_GAIN: torque_gain_q8  = value[15:0];
            REG_RPM_SCALE:   rpm_scale_q24   = value[23:0];
            REG_LOOP_PERIOD: loop_period_q24 = value[23:0];
            default: ;
        endcase
        if (idx != REG_UNUSED)
        begin
            apb_access(1'b0, idx, '0, rdata);
            check_field("prdata", setting_value(idx), rdata);
        end
    endtask

    // Sends one tick. Valid stays high from one tick to the next unless an idle
    // burst is taken; half of the bursts wait for the block to be ready first so
    // that gaps also land while the block sits waiting for input.
    task automatic send_tick(input tick_t t, input bit fixed_on, input wheel_cmd_t fixed_cmd);
        wheel_cmd_t cmd;
        if (idling_on && $urandom_range(0, 3) == 0)
        begin
            s_tvalid <= 1'b0;
            if ($urandom_range(0, 1) == 1)
            begin
                // The ready seen at the accepting edge is stale, so start looking in the next cycle.
                @(posedge clk);
                for (int w = 0; w < 100 && !s_tready; w++)
                    @(posedge clk);
            end
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        s_tdata  <= t;
        s_tvalid <= 1'b1;
        do
            @(posedge clk);
        while (!s_tready);
        cmd = predict_wheel_cmd(t);
        if (fixed_on)
            cmd = fixed_cmd;
        pending_cmds.push_back(cmd);
    endtask

    function automatic step_t tick_step(input logic [15:0] pa, input logic [15:0] pr,
                                        input logic [15:0] l_len, input logic [15:0] r_len,
                                        input logic [15:0] l_ang, input logic [15:0] r_ang,
                                        input logic [15:0] r_rpm, input logic [15:0] l_rpm,
                                        input logic en, input bit fixed_on = 1'b0,
                                        input wheel_cmd_t fixed_cmd = '0);
        step_t s;
        s.kind      = STEP_TICK;
        s.tick      = '0;
        s.reg_idx   = '0;
        s.reg_value = '0;
        s.tick.pitch_angle      = pa;
        s.tick.pitch_rate       = pr;
        s.tick.left_leg_length  = l_len;
        s.tick.right_leg_length = r_len;
        s.tick.left_leg_angle   = l_ang;
        s.tick.right_leg_angle  = r_ang;
        s.tick.right_wheel_rpm  = r_rpm;
        s.tick.left_wheel_rpm   = l_rpm;
        s.tick.lqr_enable       = en;
        s.fixed_on  = fixed_on;
        s.fixed_cmd = fixed_cmd;
        return s;
    endfunction

    function automatic step_t write_step(input logic [1:0] idx, input logic [31:0] value);
        step_t s;
        s.kind      = STEP_WRITE;
        s.tick      = '0;
        s.reg_idx   = idx;
        s.reg_value = value;
        s.fixed_on  = 1'b0;
        s.fixed_cmd = '0;
        return s;
    endfunction

    function automatic logic [15:0] near(input int center, input int spread);
        return 16'(center + int'($urandom_range(0, 2 * spread)) - spread);
    endfunction

    // Most random ticks look like a robot near balance, so the currents stay in
    // range and the gain polynomials matter; the rest use the full field ranges.
    function automatic tick_t random_tick();
        tick_t t;
        t = '0;
        t.left_leg_length  = 16'($urandom);
        t.right_leg_length = 16'($urandom);
        t.lqr_enable       = ($urandom_range(0, 19) < 17);
        if ($urandom_range(0, 9) < 7)
        begin
            t.pitch_angle     = near(0, 2000);
            t.pitch_rate      = near(0, 3000);
            t.left_leg_angle  = near(6434, 1500);
            t.right_leg_angle = near(6434, 1500);
            t.right_wheel_rpm = near(0, 3000);
            t.left_wheel_rpm  = near(0, 3000);
        end
        else
        begin
            t.pitch_angle     = 16'($urandom);
            t.pitch_rate      = 16'($urandom);
            t.left_leg_angle  = 16'($urandom);
            t.right_leg_angle = 16'($urandom);
            t.right_wheel_rpm = 16'($urandom);
            t.left_wheel_rpm  = 16'($urandom);
        end
        return t;
    endfunction

    // Register values for a random phase: the extremes now and then, otherwise
    // mostly values near the nominal setting.
    function automatic logic [31:0] pick_setting(input logic [31:0] nominal,
                                                 input logic [31:0] full_max);
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return full_max;
            2:       return $urandom_range(0, full_max);
            default: return $urandom_range(0, nominal * 4);
        endcase
    endfunction

    initial
    begin
        int items;

        // Directed list. An all-zero tick right after reset, disabled, returns the
        // cleared held currents; with zero torque gain every enabled tick gives zero.
        directed_steps.push_back(tick_step(16'h0000, 16'h0000, 16'h0000, 16'h0000,
                                           16'h0000, 16'h0000, 16'h0000, 16'h0000,
                                           1'b0, 1'b1, '0));
        directed_steps.push_back(tick_step(16'h0000, 16'h0000, 16'h0000, 16'h0000,
                                           16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b1));
        directed_steps.push_back(tick_step(16'h7FFF, 16'h7FFF, 16'hFFFF, 16'hFFFF,
                                           16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h8000, 1'b1));
        directed_steps.push_back(tick_step(16'h8000, 16'h8000, 16'h0000, 16'h0000,
                                           16'h8000, 16'h8000, 16'h8000, 16'h7FFF, 1'b1));
        directed_steps.push_back(tick_step(16'h0400, 16'hFC00, 16'hFFFF, 16'h0000,
                                           16'h1922, 16'h1922, 16'h0100, 16'hFF00, 1'b1));
        // Disabled tick: the previous currents come back, saturated is low.
        directed_steps.push_back(tick_step(16'h1234, 16'hEDCB, 16'h5555, 16'hAAAA,
                                           16'h0F0F, 16'hF0F0, 16'h0123, 16'hFEDC, 1'b0));
        directed_steps.push_back(write_step(REG_TORQUE_GAIN, 32'h0000_0000));
        directed_steps.push_back(tick_step(16'h7FFF, 16'h7FFF, 16'hFFFF, 16'hFFFF,
                                           16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h8000,
                                           1'b1, 1'b1, '0));
        // Full torque gain drives the current into clipping in both directions.
        directed_steps.push_back(write_step(REG_TORQUE_GAIN, 32'h0000_FFFF));
        directed_steps.push_back(tick_step(16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000,
                                           16'h7FFF, 16'h7FFF, 16'h0000, 16'h0000, 1'b1));
        directed_steps.push_back(tick_step(16'h8000, 16'h8000, 16'h8000, 16'h8000,
                                           16'h8000, 16'h8000, 16'h0000, 16'h0000, 1'b1));
        directed_steps.push_back(tick_step(16'h0000, 16'h0000, 16'h0000, 16'h0000,
                                           16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0));
        // Largest speed scale and tick length: the position runs into both rails.
        directed_steps.push_back(write_step(REG_RPM_SCALE, 32'h00FF_FFFF));
        directed_steps.push_back(write_step(REG_LOOP_PERIOD, 32'h00FF_FFFF));
        directed_steps.push_back(tick_step(16'h0000, 16'h0000, 16'h4000, 16'h4000,
                                           16'h1922, 16'h1922, 16'h7FFF, 16'h8000, 1'b0));
        directed_steps.push_back(tick_step(16'h0000, 16'h0000, 16'h4000, 16'h4000,
                                           16'h1922, 16'h1922, 16'h7FFF, 16'h8000, 1'b0));
        directed_steps.push_back(tick_step(16'h0000, 16'h0000, 16'h4000, 16'h4000,
                                           16'h1922, 16'h1922, 16'h7FFF, 16'h8000, 1'b1));
        directed_steps.push_back(tick_step(16'h0000, 16'h0000, 16'h4000, 16'h4000,
                                           16'h1922, 16'h1922, 16'h8000, 16'h7FFF, 1'b0));
        directed_steps.push_back(tick_step(16'h0000, 16'h0000, 16'h4000, 16'h4000,
                                           16'h1922, 16'h1922, 16'h8000, 16'h7FFF, 1'b0));
        directed_steps.push_back(tick_step(16'h0000, 16'h0000, 16'h4000, 16'h4000,
                                           16'h1922, 16'h1922, 16'h8000, 16'h7FFF, 1'b1));
        // A write to the hole in the map must leave every register alone.
        directed_steps.push_back(write_step(REG_UNUSED, 32'hFFFF_FFFF));
        directed_steps.push_back(write_step(REG_RPM_SCALE, 32'h0000_0000));
        directed_steps.push_back(write_step(REG_LOOP_PERIOD, 32'h0000_0000));
        directed_steps.push_back(tick_step(16'h0200, 16'h0100, 16'h8000, 16'h7FFF,
                                           16'h1800, 16'h1A00, 16'h1000, 16'hF000, 1'b1));

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_steps[n])
        begin
            if (directed_steps[n].kind == STEP_WRITE)
                write_setting(directed_steps[n].reg_idx, directed_steps[n].reg_value);
            else
                send_tick(directed_steps[n].tick, directed_steps[n].fixed_on,
                          directed_steps[n].fixed_cmd);
        end

        // Random phases, each under fresh register values; the last one runs
        // without any idling on either side.
        for (int phase = 0; phase < 9; phase++)
        begin
            idling_on = (phase < 8);
            write_setting(REG_TORQUE_GAIN, pick_setting(32'd256, 32'h0000_FFFF));
            write_setting(REG_RPM_SCALE, pick_setting(32'd5531, 32'h00FF_FFFF));
            write_setting(REG_LOOP_PERIOD, pick_setting(32'd16777, 32'h00FF_FFFF));
            write_setting(REG_UNUSED, $urandom);
            items = (phase < 8) ? 125 : 100;
            repeat (items) send_tick(random_tick(), 1'b0, '0);
        end

        s_tvalid <= 1'b0;
        while (pending_cmds.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
